// ===== sv/kmpt_pkg.sv =====
// Shared types and codes for the keyed minimum priority table.
// Used by the table unit and its testbench; depends on nothing else.
package kmpt_pkg;

  // Operation codes carried in the request word.
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_CHANGE = 3'd2;
  localparam logic [2:0] OP_PROBE  = 3'd3;
  localparam logic [2:0] OP_POPMIN = 3'd4;

  // Status codes carried in the response word.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [31:0]        item_key;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic               min_valid;
    logic [31:0]        min_key;
    logic signed [31:0] min_value;
    logic [10:0]        entry_count;
  } rsp_t;

  // One slot of the slot memory.
  typedef struct packed {
    logic               used;
    logic [31:0]        key;
    logic signed [31:0] value;
  } slot_t;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE,
    S_MROOT, S_MROOTD, S_MKEY,
    S_HASH,
    S_SRQ, S_SCK, S_SEND,
    S_ADDW, S_ALD, S_ALV,
    S_CLEAF, S_CRQ, S_CND, S_CNV, S_CWR,
    S_RSTART, S_RLD, S_RSRQ, S_RSCK, S_RLW, S_RPRQ, S_RPD, S_RSB, S_RSV, S_RDONE,
    S_FIN, S_FTD, S_FS, S_OUT
  } state_t;

endpackage

// ===== sv/kmpt_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// Stand-alone; no package dependency.
module kmpt_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/kmpt_hash.sv =====
// Key hash: y = ((key*101) >> 8) + key*1001, bucket = y mod BUCKETS.
// The modulo uses a reciprocal multiplication in multiply, reduce and done steps. No package use.
module kmpt_hash #(
  parameter int BUCKETS = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [31:0]                key,
  output logic                       done,
  output logic [$clog2(BUCKETS)-1:0] bucket
);

  localparam int BW = $clog2(BUCKETS);
  // Rounded-up reciprocal 2^(32+BW)/BUCKETS; exact quotients for every 32-bit y.
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << (32 + BW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [32:0] RECIP = RECIP_FULL[32:0];

  logic        busy;
  logic [1:0]  step;
  logic [31:0] y;
  logic [31:0] x;
  logic [64:0] prod;
  logic [31:0] quo;
  logic [31:0] rem;

  assign x      = key * 32'd101;
  assign quo    = 32'(prod >> (32 + BW));
  assign done   = busy && (step == 2'd2);
  assign bucket = rem[BW-1:0];

  // Sequencing of the multiply, reduce and done steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      if (step == 2'd2) begin
        busy <= 1'b0;
      end else begin
        step <= step + 2'd1;
      end
    end
  end

  // Hash word, product with the reciprocal and the remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      y <= (x >> 8) + key * 32'd1001;
    end
    if (busy && (step == 2'd0)) begin
      prod <= 65'(y) * 65'(RECIP);
    end
    if (busy && (step == 2'd1)) begin
      rem <= y - quo * 32'(BUCKETS);
    end
  end

endmodule

// ===== sv/keyed_min_priority_table_unit.sv =====
// Keyed minimum priority table: add, remove, change, probe and remove-minimum on
// keyed Q16.16 values, one operation at a time, one response word per request word.
// Entries live in a slot memory of BUCKETS*WAYS words; a tournament tree over the
// bucket minima lives in a second memory of 2*BUCKETS nodes. An operation runs key
// hashing (a reciprocal multiplication for the modulo), bucket scans (a key search,
// and a rescan when the entry taken out was its bucket's minimum), tree walks over
// log2(BUCKETS) levels and a hand-off; the shortest runs are an unused code or an
// empty table, the longest a change that rebuilds one tree path and climbs another.
// After reset a clearing pass writes every address of both memories before the
// first word is taken. Depends on kmpt_pkg, kmpt_ram and kmpt_hash.
module keyed_min_priority_table_unit #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  kmpt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output kmpt_pkg::rsp_t rsp
);

  localparam int NSLOTS = BUCKETS * WAYS;
  localparam int TN     = 2 * BUCKETS;
  localparam int SW     = $clog2(NSLOTS);
  localparam int NW     = SW + 1;
  localparam int TW     = $clog2(TN);
  localparam int BW     = $clog2(BUCKETS);
  localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNTW   = $clog2(NSLOTS + 1);
  localparam int CLRN   = (NSLOTS > TN) ? NSLOTS : TN;
  localparam int KW     = $clog2(CLRN);
  localparam int SLW    = $bits(kmpt_pkg::slot_t);

  kmpt_pkg::state_t state, state_next;

  // Operation registers.
  logic [2:0]         op;
  logic [31:0]        key;
  logic signed [31:0] val;
  logic [BW-1:0]      b;
  logic [SW-1:0]      base;
  logic [WW-1:0]      w;
  logic [WW-1:0]      hw;
  logic [WW-1:0]      fw;
  logic               hit;
  logic               got;
  logic [SW-1:0]      s;
  logic [TW-1:0]      i;
  logic [TW-1:0]      c;
  logic [NW-1:0]      cur;
  logic signed [31:0] cur_val;
  logic [NW-1:0]      best;
  logic signed [31:0] bval;
  logic [NW-1:0]      sib;
  logic [1:0]         status;
  logic               found;
  logic [CNTW-1:0]    held;
  logic               mvalid;
  logic [31:0]        mkey;
  logic signed [31:0] mval;
  logic [KW-1:0]      clr;

  // Memory ports.
  logic                 slot_we;
  logic [SW-1:0]        slot_waddr;
  kmpt_pkg::slot_t      slot_wdata;
  logic [SW-1:0]        slot_raddr;
  logic [SLW-1:0]       slot_rbits;
  kmpt_pkg::slot_t      sd;
  logic                 tree_we;
  logic [TW-1:0]        tree_waddr;
  logic [NW-1:0]        tree_wdata;
  logic [TW-1:0]        tree_raddr;
  logic [NW-1:0]        tn;

  // Hash unit.
  logic          hs_start;
  logic [31:0]   hs_key;
  logic          hdone;
  logic [BW-1:0] hbucket;

  // Derived values.
  logic               acc;
  logic               out_free;
  logic [SW-1:0]      t;
  logic [TW-1:0]      leaf;
  logic [NW-1:0]      s1;
  logic [SW-1:0]      tn_slot;
  logic               match;
  logic               w_last;
  logic [NW-1:0]      pick;
  logic signed [31:0] pick_val;

  assign sd       = kmpt_pkg::slot_t'(slot_rbits);
  assign acc      = req_valid && !req_stall;
  assign req_stall = (state != kmpt_pkg::S_IDLE);
  assign out_free = !rsp_valid || !rsp_stall;
  assign t        = SW'(base + SW'(w));
  assign leaf     = TW'(BUCKETS) + TW'(b);
  assign s1       = NW'(s) + NW'(1);
  assign tn_slot  = SW'(tn - NW'(1));
  assign match    = sd.used && (sd.key == key);
  assign w_last   = (w == WW'(WAYS - 1));

  // Rebuilt parent node: the right child wins ties.
  always_comb begin
    if (cur == '0) begin
      pick     = sib;
      pick_val = sd.value;
    end else if (!c[0]) begin
      if (cur_val < sd.value) begin
        pick     = cur;
        pick_val = cur_val;
      end else begin
        pick     = sib;
        pick_val = sd.value;
      end
    end else begin
      if (sd.value < cur_val) begin
        pick     = sib;
        pick_val = sd.value;
      end else begin
        pick     = cur;
        pick_val = cur_val;
      end
    end
  end

  // Hash starts for the request key, or for the key of the root on remove-minimum.
  assign hs_start = (acc && (req.opcode inside {kmpt_pkg::OP_ADD, kmpt_pkg::OP_REMOVE,
                                                kmpt_pkg::OP_CHANGE, kmpt_pkg::OP_PROBE}))
                    || (state == kmpt_pkg::S_MKEY);
  assign hs_key   = (state == kmpt_pkg::S_MKEY) ? sd.key : req.item_key;

  kmpt_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hs_start),
    .key    (hs_key),
    .done   (hdone),
    .bucket (hbucket)
  );

  kmpt_ram #(.W(SLW), .D(NSLOTS)) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rbits)
  );

  kmpt_ram #(.W(NW), .D(TN)) u_tree (
    .clk   (clk),
    .we    (tree_we),
    .waddr (tree_waddr),
    .wdata (tree_wdata),
    .raddr (tree_raddr),
    .rdata (tn)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      kmpt_pkg::S_CLEAR: if (clr == KW'(CLRN - 1)) state_next = kmpt_pkg::S_IDLE;
      kmpt_pkg::S_IDLE: begin
        if (acc) begin
          if (req.opcode == kmpt_pkg::OP_POPMIN) begin
            state_next = kmpt_pkg::S_MROOT;
          end else if (req.opcode inside {kmpt_pkg::OP_ADD, kmpt_pkg::OP_REMOVE,
                                          kmpt_pkg::OP_CHANGE, kmpt_pkg::OP_PROBE}) begin
            state_next = kmpt_pkg::S_HASH;
          end else begin
            state_next = kmpt_pkg::S_FIN;
          end
        end
      end
      kmpt_pkg::S_MROOT:  state_next = kmpt_pkg::S_MROOTD;
      kmpt_pkg::S_MROOTD: state_next = (tn == '0) ? kmpt_pkg::S_FIN : kmpt_pkg::S_MKEY;
      kmpt_pkg::S_MKEY:   state_next = kmpt_pkg::S_HASH;
      kmpt_pkg::S_HASH: begin
        if (hdone) begin
          state_next = (op == kmpt_pkg::OP_POPMIN) ? kmpt_pkg::S_RSTART : kmpt_pkg::S_SRQ;
        end
      end
      kmpt_pkg::S_SRQ: state_next = kmpt_pkg::S_SCK;
      kmpt_pkg::S_SCK: state_next = w_last ? kmpt_pkg::S_SEND : kmpt_pkg::S_SRQ;
      kmpt_pkg::S_SEND: begin
        case (op)
          kmpt_pkg::OP_ADD:    state_next = got ? kmpt_pkg::S_ADDW : kmpt_pkg::S_FIN;
          kmpt_pkg::OP_REMOVE: state_next = hit ? kmpt_pkg::S_RSTART : kmpt_pkg::S_FIN;
          kmpt_pkg::OP_CHANGE: begin
            if (hit) begin
              state_next = kmpt_pkg::S_RSTART;
            end else begin
              state_next = got ? kmpt_pkg::S_ADDW : kmpt_pkg::S_FIN;
            end
          end
          default: state_next = kmpt_pkg::S_FIN;
        endcase
      end
      kmpt_pkg::S_ADDW: state_next = kmpt_pkg::S_ALD;
      kmpt_pkg::S_ALD:  state_next = (tn == '0) ? kmpt_pkg::S_CLEAF : kmpt_pkg::S_ALV;
      kmpt_pkg::S_ALV:  state_next = (val < sd.value) ? kmpt_pkg::S_CLEAF : kmpt_pkg::S_FIN;
      kmpt_pkg::S_CLEAF: state_next = kmpt_pkg::S_CRQ;
      kmpt_pkg::S_CRQ:   state_next = kmpt_pkg::S_CND;
      kmpt_pkg::S_CND:   state_next = (tn == '0) ? kmpt_pkg::S_CWR : kmpt_pkg::S_CNV;
      kmpt_pkg::S_CNV:   state_next = (val >= sd.value) ? kmpt_pkg::S_FIN : kmpt_pkg::S_CWR;
      kmpt_pkg::S_CWR:   state_next = (i == TW'(1)) ? kmpt_pkg::S_FIN : kmpt_pkg::S_CRQ;
      kmpt_pkg::S_RSTART: state_next = kmpt_pkg::S_RLD;
      kmpt_pkg::S_RLD:  state_next = (tn != s1) ? kmpt_pkg::S_RDONE : kmpt_pkg::S_RSRQ;
      kmpt_pkg::S_RSRQ: state_next = kmpt_pkg::S_RSCK;
      kmpt_pkg::S_RSCK: state_next = w_last ? kmpt_pkg::S_RLW : kmpt_pkg::S_RSRQ;
      kmpt_pkg::S_RLW:  state_next = kmpt_pkg::S_RPRQ;
      kmpt_pkg::S_RPRQ: state_next = kmpt_pkg::S_RPD;
      kmpt_pkg::S_RPD:  state_next = (tn != s1) ? kmpt_pkg::S_RDONE : kmpt_pkg::S_RSB;
      kmpt_pkg::S_RSB: begin
        if (tn != '0) begin
          state_next = kmpt_pkg::S_RSV;
        end else begin
          state_next = (i == TW'(1)) ? kmpt_pkg::S_RDONE : kmpt_pkg::S_RPRQ;
        end
      end
      kmpt_pkg::S_RSV: state_next = (i == TW'(1)) ? kmpt_pkg::S_RDONE : kmpt_pkg::S_RPRQ;
      kmpt_pkg::S_RDONE: begin
        state_next = (op == kmpt_pkg::OP_CHANGE) ? kmpt_pkg::S_ADDW : kmpt_pkg::S_FIN;
      end
      kmpt_pkg::S_FIN: state_next = kmpt_pkg::S_FTD;
      kmpt_pkg::S_FTD: state_next = (tn == '0) ? kmpt_pkg::S_OUT : kmpt_pkg::S_FS;
      kmpt_pkg::S_FS:  state_next = kmpt_pkg::S_OUT;
      kmpt_pkg::S_OUT: if (out_free) state_next = kmpt_pkg::S_IDLE;
      default: state_next = kmpt_pkg::S_IDLE;
    endcase
  end

  // Memory port control for each state.
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = s;
    slot_wdata = '0;
    slot_raddr = t;
    tree_we    = 1'b0;
    tree_waddr = i;
    tree_wdata = s1;
    tree_raddr = i;
    case (state)
      kmpt_pkg::S_CLEAR: begin
        slot_we    = (32'(clr) < NSLOTS);
        slot_waddr = SW'(clr);
        tree_we    = (32'(clr) < TN);
        tree_waddr = TW'(clr);
        tree_wdata = '0;
      end
      kmpt_pkg::S_MROOT:  tree_raddr = TW'(1);
      kmpt_pkg::S_MROOTD: slot_raddr = tn_slot;
      kmpt_pkg::S_ADDW: begin
        slot_we    = 1'b1;
        slot_waddr = SW'(base + SW'(fw));
        slot_wdata = '{used: 1'b1, key: key, value: val};
        tree_raddr = leaf;
      end
      kmpt_pkg::S_ALD: slot_raddr = tn_slot;
      kmpt_pkg::S_CLEAF: begin
        tree_we    = 1'b1;
        tree_waddr = leaf;
      end
      kmpt_pkg::S_CND: slot_raddr = tn_slot;
      kmpt_pkg::S_CWR: tree_we = 1'b1;
      kmpt_pkg::S_RSTART: begin
        slot_we    = 1'b1;
        tree_raddr = leaf;
      end
      kmpt_pkg::S_RLW: begin
        tree_we    = 1'b1;
        tree_waddr = leaf;
        tree_wdata = best;
      end
      kmpt_pkg::S_RPD: tree_raddr = {c[TW-1:1], ~c[0]};
      kmpt_pkg::S_RSB: begin
        slot_raddr = tn_slot;
        tree_we    = (tn == '0);
        tree_wdata = cur;
      end
      kmpt_pkg::S_RSV: begin
        tree_we    = 1'b1;
        tree_wdata = pick;
      end
      kmpt_pkg::S_FIN: tree_raddr = TW'(1);
      kmpt_pkg::S_FTD: slot_raddr = tn_slot;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kmpt_pkg::S_CLEAR;
      clr       <= '0;
      held      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == kmpt_pkg::S_CLEAR) begin
        clr <= KW'(clr + KW'(1));
      end
      if (state == kmpt_pkg::S_ADDW) begin
        held <= held + CNTW'(1);
      end else if (state == kmpt_pkg::S_RSTART) begin
        held <= held - CNTW'(1);
      end
      if ((state == kmpt_pkg::S_OUT) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Operation datapath.
  always_ff @(posedge clk) begin
    case (state)
      kmpt_pkg::S_IDLE: begin
        if (acc) begin
          op     <= req.opcode;
          key    <= req.item_key;
          val    <= req.item_value;
          status <= kmpt_pkg::ST_OK;
          found  <= 1'b0;
          hit    <= 1'b0;
          got    <= 1'b0;
          hw     <= '0;
          fw     <= '0;
        end
      end
      kmpt_pkg::S_MROOTD: begin
        if (tn == '0) begin
          status <= kmpt_pkg::ST_EMPTY;
        end else begin
          s <= tn_slot;
        end
      end
      kmpt_pkg::S_MKEY: found <= 1'b1;
      kmpt_pkg::S_HASH: begin
        if (hdone) begin
          b    <= hbucket;
          base <= SW'(32'(hbucket) * 32'(WAYS));
          w    <= '0;
        end
      end
      kmpt_pkg::S_SCK: begin
        if (match && !hit) begin
          hit <= 1'b1;
          hw  <= w;
        end
        if ((!sd.used || ((op == kmpt_pkg::OP_CHANGE) && match && !hit)) && !got) begin
          got <= 1'b1;
          fw  <= w;
        end
        w <= WW'(w + WW'(1));
      end
      kmpt_pkg::S_SEND: begin
        case (op)
          kmpt_pkg::OP_ADD: if (!got) status <= kmpt_pkg::ST_FULL;
          kmpt_pkg::OP_REMOVE: begin
            if (hit) begin
              found <= 1'b1;
              s     <= SW'(base + SW'(hw));
            end else begin
              status <= kmpt_pkg::ST_NOTFOUND;
            end
          end
          kmpt_pkg::OP_CHANGE: begin
            if (hit) begin
              found <= 1'b1;
              s     <= SW'(base + SW'(hw));
            end else if (!got) begin
              status <= kmpt_pkg::ST_FULL;
            end
          end
          kmpt_pkg::OP_PROBE: begin
            found  <= hit;
            status <= hit ? kmpt_pkg::ST_OK : kmpt_pkg::ST_NOTFOUND;
          end
          default: ;
        endcase
      end
      kmpt_pkg::S_ADDW:  s <= SW'(base + SW'(fw));
      kmpt_pkg::S_CLEAF: i <= leaf >> 1;
      kmpt_pkg::S_CWR:   i <= i >> 1;
      kmpt_pkg::S_RLD: begin
        w    <= '0;
        best <= '0;
      end
      kmpt_pkg::S_RSCK: begin
        if (sd.used && (t != s) && ((best == '0) || (sd.value < bval))) begin
          best <= NW'(t) + NW'(1);
          bval <= sd.value;
        end
        w <= WW'(w + WW'(1));
      end
      kmpt_pkg::S_RLW: begin
        cur     <= best;
        cur_val <= bval;
        c       <= leaf;
        i       <= leaf >> 1;
      end
      kmpt_pkg::S_RSB: begin
        sib <= tn;
        if (tn == '0) begin
          c <= i;
          i <= i >> 1;
        end
      end
      kmpt_pkg::S_RSV: begin
        cur     <= pick;
        cur_val <= pick_val;
        c       <= i;
        i       <= i >> 1;
      end
      kmpt_pkg::S_FTD: begin
        mvalid <= 1'b0;
        mkey   <= '0;
        mval   <= '0;
      end
      kmpt_pkg::S_FS: begin
        mvalid <= 1'b1;
        mkey   <= sd.key;
        mval   <= sd.value;
      end
      default: ;
    endcase
  end

  // Response word.
  always_ff @(posedge clk) begin
    if ((state == kmpt_pkg::S_OUT) && out_free) begin
      rsp.status      <= status;
      rsp.found       <= found;
      rsp.min_valid   <= mvalid;
      rsp.min_key     <= mkey;
      rsp.min_value   <= mval;
      rsp.entry_count <= 11'(held);
    end
  end

endmodule

// ===== test/tb_keyed_min_priority_table_unit.sv =====
// Testbench for the keyed minimum priority table: a directed table of operations,
// then random keyed traffic, each response word checked against a behavioural table.
// Depends on kmpt_pkg and the keyed_min_priority_table_unit RTL.
`timescale 1ns / 1ps

module tb_keyed_min_priority_table_unit;

  localparam int BUCKETS = 256;
  localparam int WAYS = 4;
  localparam int NSLOTS = BUCKETS * WAYS;
  localparam int RANDOM_OPS = 1200;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  kmpt_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall;
  kmpt_pkg::rsp_t rsp;

  keyed_min_priority_table_unit #(.BUCKETS(BUCKETS), .WAYS(WAYS)) i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // Shadow copy of the table.
  logic [31:0] shadow_key [NSLOTS];
  logic [31:0] shadow_val [NSLOTS];
  logic        shadow_used [NSLOTS];
  int unsigned shadow_tree [2*BUCKETS];
  int unsigned shadow_count;

  kmpt_pkg::rsp_t pending_rsp [$];
  int mismatches;
  int words_in;
  int words_out;
  longint cycle_count;
  bit sending_done;
  bit quiet_phase;
  bit hold_off;
  logic [31:0] used_keys [$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] ord_of(logic [31:0] v);
    return v ^ 32'h8000_0000;
  endfunction

  function automatic int unsigned bucket_for(logic [31:0] k);
    logic [31:0] x;
    logic [31:0] y;
    x = k * 32'd101;
    y = (x >> 8) + k * 32'd1001;
    return y % BUCKETS;
  endfunction

  function automatic logic [31:0] node_ord(int unsigned n);
    return ord_of(shadow_val[n-1]);
  endfunction

  function automatic int unsigned lookup_slot(int unsigned b, logic [31:0] k);
    for (int w = 0; w < WAYS; w++) begin
      if (shadow_used[b*WAYS+w] && shadow_key[b*WAYS+w] == k) return b*WAYS + w + 1;
    end
    return 0;
  endfunction

  // Insert into the bucket's first free way and push a new minimum up the tree.
  function automatic logic [1:0] insert_entry(logic [31:0] k, logic [31:0] v);
    int unsigned b;
    int unsigned s;
    int unsigned i;
    bit got;
    b = bucket_for(k);
    got = 0;
    s = 0;
    for (int w = 0; w < WAYS; w++) begin
      if (!got && !shadow_used[b*WAYS+w]) begin
        s = b*WAYS + w;
        got = 1;
      end
    end
    if (!got) return kmpt_pkg::ST_FULL;
    shadow_used[s] = 1;
    shadow_key[s] = k;
    shadow_val[s] = v;
    shadow_count++;
    i = BUCKETS + b;
    if (shadow_tree[i] == 0 || ord_of(v) < node_ord(shadow_tree[i])) begin
      shadow_tree[i] = s + 1;
      while (i > 1) begin
        i >>= 1;
        if (shadow_tree[i] != 0 && ord_of(v) >= node_ord(shadow_tree[i])) break;
        shadow_tree[i] = s + 1;
      end
    end
    return kmpt_pkg::ST_OK;
  endfunction

  // Free a slot; if it was the bucket minimum, rescan and rebuild the path.
  function automatic void evict_slot(int unsigned b, int unsigned s);
    int unsigned i;
    int unsigned best;
    int unsigned l;
    int unsigned r;
    i = BUCKETS + b;
    best = 0;
    shadow_used[s] = 0;
    shadow_count--;
    if (shadow_tree[i] != s + 1) return;
    for (int w = 0; w < WAYS; w++) begin
      if (shadow_used[b*WAYS+w] &&
          (best == 0 || ord_of(shadow_val[b*WAYS+w]) < node_ord(best)))
        best = b*WAYS + w + 1;
    end
    shadow_tree[i] = best;
    while (i > 1) begin
      i >>= 1;
      if (shadow_tree[i] != s + 1) break;
      l = shadow_tree[2*i];
      r = shadow_tree[2*i+1];
      if (l == 0) shadow_tree[i] = r;
      else if (r == 0) shadow_tree[i] = l;
      else shadow_tree[i] = (node_ord(l) < node_ord(r)) ? l : r;
    end
  endfunction

  function automatic kmpt_pkg::rsp_t apply_op(kmpt_pkg::req_t q);
    kmpt_pkg::rsp_t o;
    int unsigned b;
    int unsigned hit;
    int unsigned root;
    o = '0;
    b = bucket_for(q.item_key);
    case (q.opcode)
      kmpt_pkg::OP_ADD: o.status = insert_entry(q.item_key, q.item_value);
      kmpt_pkg::OP_REMOVE: begin
        hit = lookup_slot(b, q.item_key);
        if (hit != 0) begin
          o.found = 1;
          evict_slot(b, hit - 1);
        end else o.status = kmpt_pkg::ST_NOTFOUND;
      end
      kmpt_pkg::OP_CHANGE: begin
        hit = lookup_slot(b, q.item_key);
        if (hit != 0) begin
          o.found = 1;
          evict_slot(b, hit - 1);
        end
        o.status = insert_entry(q.item_key, q.item_value);
      end
      kmpt_pkg::OP_PROBE: begin
        if (lookup_slot(b, q.item_key) != 0) o.found = 1;
        else o.status = kmpt_pkg::ST_NOTFOUND;
      end
      kmpt_pkg::OP_POPMIN: begin
        root = shadow_tree[1];
        if (root == 0) o.status = kmpt_pkg::ST_EMPTY;
        else begin
          o.found = 1;
          evict_slot(bucket_for(shadow_key[root-1]), root - 1);
        end
      end
      default: ;
    endcase
    root = shadow_tree[1];
    o.min_valid = (root != 0);
    o.min_key = (root != 0) ? shadow_key[root-1] : '0;
    o.min_value = (root != 0) ? shadow_val[root-1] : '0;
    o.entry_count = shadow_count[10:0];
    return o;
  endfunction

  // Directed rows: an expected word is given only where it is plain at a glance.
  typedef struct {
    kmpt_pkg::req_t q;
    bit             typed;
    kmpt_pkg::rsp_t r;
  } row_t;

  row_t directed [$];
  kmpt_pkg::rsp_t typed_rsp [$];
  bit   typed_flag [$];

  function automatic kmpt_pkg::rsp_t mk_rsp(logic [1:0] st, logic f, logic mv,
                                            logic [31:0] mk, logic [31:0] mval,
                                            logic [10:0] cnt);
    kmpt_pkg::rsp_t r;
    r.status = st; r.found = f; r.min_valid = mv; r.min_key = mk;
    r.min_value = mval; r.entry_count = cnt;
    return r;
  endfunction

  function automatic void add_row(logic [2:0] op, logic [31:0] k, logic [31:0] v,
                                  bit typed, kmpt_pkg::rsp_t r);
    row_t w;
    w.q.opcode = op; w.q.item_key = k; w.q.item_value = v;
    w.typed = typed; w.r = r;
    directed.push_back(w);
  endfunction

  // Keys that all land in the bucket of key zero, to fill a bucket.
  function automatic void same_bucket_keys(int n, ref logic [31:0] ks [$]);
    logic [31:0] k;
    int unsigned b0;
    b0 = bucket_for(32'd0);
    k = 32'd1;
    while (ks.size() < n) begin
      if (bucket_for(k) == b0) ks.push_back(k);
      k++;
    end
  endfunction

  function automatic logic [31:0] pick_key();
    if (used_keys.size() > 0 && $urandom_range(0, 99) < 65)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 63);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 7) << 16;
      default: return $urandom;
    endcase
  endfunction

  // Offer one word and hold it until the block accepts it.
  task automatic send_word(kmpt_pkg::req_t q);
    if (!quiet_phase) begin
      while ($urandom_range(0, 99) < 11) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    req <= q;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    words_in++;
    pending_rsp.push_back(apply_op(q));
  endtask

  // Stimulus: reset, directed table, then random traffic.
  initial begin
    logic [31:0] ks [$];
    kmpt_pkg::req_t q;
    int r;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    sending_done = 0;
    quiet_phase = 0;
    words_in = 0;
    shadow_count = 0;
    for (int s = 0; s < NSLOTS; s++) begin
      shadow_used[s] = 0; shadow_key[s] = '0; shadow_val[s] = '0;
    end
    for (int n = 0; n < 2*BUCKETS; n++) shadow_tree[n] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    same_bucket_keys(WAYS + 1, ks);
    // Empty table: pop, probe and remove report on an empty table; then an unused code and two adds.
    add_row(kmpt_pkg::OP_POPMIN, 32'd0, 32'd0, 1,
            mk_rsp(kmpt_pkg::ST_EMPTY, 0, 0, 0, 0, 0));
    add_row(kmpt_pkg::OP_PROBE, 32'hFFFF_FFFF, 32'd0, 1,
            mk_rsp(kmpt_pkg::ST_NOTFOUND, 0, 0, 0, 0, 0));
    add_row(kmpt_pkg::OP_REMOVE, 32'd0, 32'd0, 1,
            mk_rsp(kmpt_pkg::ST_NOTFOUND, 0, 0, 0, 0, 0));
    add_row(3'd5, 32'd7, 32'd7, 1, mk_rsp(kmpt_pkg::ST_OK, 0, 0, 0, 0, 0));
    add_row(kmpt_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1,
            mk_rsp(kmpt_pkg::ST_OK, 0, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1));
    add_row(kmpt_pkg::OP_ADD, 32'd0, 32'h8000_0000, 1,
            mk_rsp(kmpt_pkg::ST_OK, 0, 1, 32'd0, 32'h8000_0000, 2));
    // Fill the bucket of key zero, overflow it by add and by change, then probe, remove, change, unused codes and pops.
    for (int i = 0; i < WAYS - 1; i++)
      add_row(kmpt_pkg::OP_ADD, ks[i], 32'h8000_0000, 0, '0);
    add_row(kmpt_pkg::OP_ADD, ks[WAYS], 32'd5, 0, '0);
    add_row(kmpt_pkg::OP_CHANGE, ks[WAYS], 32'd5, 0, '0);
    add_row(kmpt_pkg::OP_ADD, ks[0], 32'h8000_0000, 0, '0);
    add_row(kmpt_pkg::OP_PROBE, ks[0], 32'd0, 0, '0);
    add_row(kmpt_pkg::OP_REMOVE, ks[0], 32'd0, 0, '0);
    add_row(kmpt_pkg::OP_ADD, ks[0], 32'h8000_0000, 0, '0);
    add_row(kmpt_pkg::OP_CHANGE, ks[1], 32'h0001_0000, 0, '0);
    add_row(kmpt_pkg::OP_CHANGE, 32'h1234_5678, 32'hFFFF_0000, 0, '0);
    add_row(3'd6, 32'd0, 32'd0, 0, '0);
    add_row(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0);
    for (int i = 0; i < 5; i++) add_row(kmpt_pkg::OP_POPMIN, 32'd0, 32'd0, 0, '0);

    foreach (directed[i]) begin
      typed_flag.push_back(directed[i].typed);
      typed_rsp.push_back(directed[i].r);
      send_word(directed[i].q);
    end

    // Random traffic: the same mix of operations throughout, adds the most common; a quiet stretch mid-way.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      quiet_phase = (n >= 400 && n < 600);
      r = $urandom_range(0, 99);
      q.item_value = pick_value();
      q.item_key = pick_key();
      if (r < 35) q.opcode = kmpt_pkg::OP_ADD;
      else if (r < 50) q.opcode = kmpt_pkg::OP_REMOVE;
      else if (r < 65) q.opcode = kmpt_pkg::OP_CHANGE;
      else if (r < 78) q.opcode = kmpt_pkg::OP_PROBE;
      else if (r < 96) q.opcode = kmpt_pkg::OP_POPMIN;
      else q.opcode = 3'($urandom_range(5, 7));
      if (q.opcode == kmpt_pkg::OP_ADD) used_keys.push_back(q.item_key);
      if (used_keys.size() > 200) void'(used_keys.pop_front());
      typed_flag.push_back(0);
      typed_rsp.push_back('0);
      send_word(q);
    end
    req_valid <= 1'b0;
    sending_done = 1;
  end

  // Receiver: random stalls, one long hold-off during which the block stalls the sender.
  initial begin
    rsp_stall = 1'b1;
    hold_off = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!hold_off && words_in == 300) begin
        hold_off = 1;
        rsp_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      rsp_stall <= !quiet_phase && ($urandom_range(0, 99) < 11);
    end
  end

  // Response checker.
  initial begin
    kmpt_pkg::rsp_t exp;
    bit typed;
    kmpt_pkg::rsp_t fixed;
    mismatches = 0;
    words_out = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Response word with none expected: %p", rsp);
        end else begin
          exp = pending_rsp.pop_front();
          typed = typed_flag.pop_front();
          fixed = typed_rsp.pop_front();
          if (typed && fixed != exp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Table row %0d disagrees with predictor: %p vs %p",
                       words_out, fixed, exp);
          end
          if (rsp.status !== exp.status || rsp.found !== exp.found ||
              rsp.min_valid !== exp.min_valid || rsp.min_key !== exp.min_key ||
              rsp.min_value !== exp.min_value || rsp.entry_count !== exp.entry_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Word %0d mismatch: expected %p, got %p", words_out, exp, rsp);
          end
        end
        words_out++;
      end
    end
  end

  // End of run and timeout.
  initial begin
    cycle_count = 0;
    fork
      begin
        wait (sending_done);
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
      end
      begin
        while (cycle_count < CYCLE_LIMIT) begin
          @(posedge clk);
          cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d words outstanding",
                 cycle_count, pending_rsp.size());
        $display("Simulation FAILED");
        $finish;
      end
    join_any
    $display("Covered %0d request words and %0d response words, %0d mismatches.",
             words_in, words_out, mismatches);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
